/* rtl/smpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and codes for the sorted max-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [COUNT_W-1:0]       count_t;

  typedef enum logic [0:0] {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/smpq_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_ifs
// Valid/ready channels for queue commands and queue results.
// ----------------------------------------------------------------------------
interface smpq_in_if;
  logic                valid;
  logic                ready;
  smpq_pkg::op_t       opcode;
  smpq_pkg::data_t     value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface smpq_out_if;
  logic                valid;
  logic                ready;
  smpq_pkg::data_t     head_value;
  smpq_pkg::data_t     removed_value;
  logic                is_empty;
  smpq_pkg::count_t    entry_count;
  smpq_pkg::status_t   status;

  modport source (output valid, output head_value, output removed_value,
                  output is_empty, output entry_count, output status, input ready);
  modport sink   (input valid, input head_value, input removed_value,
                  input is_empty, input entry_count, input status, output ready);
endinterface
`default_nettype wire

/* rtl/sorted_max_priority_queue_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_unit
// Bounded max-priority queue built as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Accepts one enqueue or dequeue per clock cycle while no stalled result
// blocks the input, and returns one result per command, registered, in the
// cycle after the transfer. The per-cycle figure is set by each cell's single
// 32-bit compare against the broadcast key; every cell shifts, inserts or
// holds in the same cycle, so no search loop exists. Equal values are ordered
// newest first. An enqueue into a full queue is dropped with status ST_FULL;
// a dequeue from an empty queue returns ST_EMPTY. New commands are taken while
// a result waits as long as that result is being taken in the same cycle.
module sorted_max_priority_queue_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  smpq_in_if.sink    in_ch,
  smpq_out_if.source out_ch
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r;
  smpq_pkg::data_t      head_r, removed_r;
  logic                 empty_flag_r;
  smpq_pkg::count_t     entry_count_r;
  smpq_pkg::status_t    status_r;

  smpq_pkg::data_t      head_nxt, removed_nxt;
  smpq_pkg::status_t    status_nxt;

  logic                 fire, full, empty, enq_ok, deq_ok;
  smpq_pkg::cell_ctrl_t ctrl;

  smpq_pkg::data_t      val_w [CAPACITY];
  logic                 gt_w  [CAPACITY];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign empty       = (count_r == '0);
  assign enq_ok      = fire && (in_ch.opcode == smpq_pkg::OP_ENQUEUE) && !full;
  assign deq_ok      = fire && (in_ch.opcode == smpq_pkg::OP_DEQUEUE) && !empty;
  assign ctrl        = '{enq: enq_ok, deq: deq_ok};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            occ;
    logic            pgt;
    smpq_pkg::data_t pval, nval;

    assign occ = (count_r > CNT_W'(i));
    if (i == 0) begin : g_first
      assign pgt  = 1'b1;
      assign pval = in_ch.value;
    end else begin : g_mid
      assign pgt  = gt_w[i-1];
      assign pval = val_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign nval = val_w[i];
    end else begin : g_inner
      assign nval = val_w[i+1];
    end

    smpq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .key      (in_ch.value),
      .occupied (occ),
      .prev_gt  (pgt),
      .prev_val (pval),
      .next_val (nval),
      .val      (val_w[i]),
      .gt       (gt_w[i])
    );
  end

  always_comb begin
    count_nxt   = count_r;
    head_nxt    = empty ? '0 : val_w[0];
    removed_nxt = '0;
    status_nxt  = smpq_pkg::ST_OK;
    if (fire) begin
      if (in_ch.opcode == smpq_pkg::OP_ENQUEUE) begin
        if (full) begin
          status_nxt = smpq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          head_nxt  = gt_w[0] ? val_w[0] : in_ch.value;
        end
      end else begin
        if (empty) begin
          status_nxt = smpq_pkg::ST_EMPTY;
        end else begin
          count_nxt   = count_r - CNT_W'(1);
          removed_nxt = val_w[0];
          head_nxt    = (count_r > CNT_W'(1)) ? val_w[1] : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      head_r        <= head_nxt;
      removed_r     <= removed_nxt;
      empty_flag_r  <= (count_nxt == '0);
      entry_count_r <= smpq_pkg::COUNT_W'(count_nxt);
      status_r      <= status_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.head_value    = head_r;
  assign out_ch.removed_value = removed_r;
  assign out_ch.is_empty      = empty_flag_r;
  assign out_ch.entry_count   = entry_count_r;
  assign out_ch.status        = status_r;

endmodule
`default_nettype wire

/* rtl/smpq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: holds a value, compares it with the incoming
// key and takes its own, the key, or a neighbor's value each cycle.
// ----------------------------------------------------------------------------
module smpq_cell (
  input  wire logic                  clk,
  input  wire smpq_pkg::cell_ctrl_t  ctrl,
  input  wire smpq_pkg::data_t       key,
  input  wire logic                  occupied,
  input  wire logic                  prev_gt,
  input  wire smpq_pkg::data_t       prev_val,
  input  wire smpq_pkg::data_t       next_val,
  output smpq_pkg::data_t            val,
  output logic                       gt
);

  smpq_pkg::data_t val_r;
  smpq_pkg::data_t val_nxt;

  assign gt  = occupied && (val_r > key);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.enq) begin
      if (!gt) begin
        val_nxt = prev_gt ? key : prev_val;
      end
    end else if (ctrl.deq) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

/* rtl/smpq_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks on the queue's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module smpq_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire smpq_pkg::data_t   head_value,
  input wire smpq_pkg::data_t   removed_value,
  input wire logic              is_empty,
  input wire smpq_pkg::count_t  entry_count,
  input wire smpq_pkg::status_t status
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(head_value)
      && $stable(removed_value) && $stable(entry_count) && $stable(status))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> is_empty == (entry_count == '0))
    else $error("empty flag disagrees with count");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_empty |-> head_value == '0)
    else $error("empty queue reports nonzero head");

  a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == smpq_pkg::ST_EMPTY |-> is_empty && removed_value == '0)
    else $error("dequeue on empty reported wrongly");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == smpq_pkg::ST_FULL
      |-> entry_count == smpq_pkg::COUNT_W'(CAPACITY) && removed_value == '0)
    else $error("dropped enqueue without a full queue");

endmodule

bind sorted_max_priority_queue_unit smpq_checker #(.CAPACITY(CAPACITY)) u_smpq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .head_value    (out_ch.head_value),
  .removed_value (out_ch.removed_value),
  .is_empty      (out_ch.is_empty),
  .entry_count   (out_ch.entry_count),
  .status        (out_ch.status)
);
`default_nettype wire
